/* rtl/core/bwbq_pkg.sv */
// Shared command codes, register indexes and controller-to-datapath types for the biquad.
`timescale 1ns / 1ps

package bwbq_pkg;

   // Register indexes on the configuration port
   localparam logic [1:0] CSR_FILTER_MODE = 2'd0;
   localparam logic [1:0] CSR_COEF_GAIN   = 2'd1;
   localparam logic [1:0] CSR_COEF_FB1    = 2'd2;
   localparam logic [1:0] CSR_COEF_FB2    = 2'd3;

   // Multiplier operand selection: coefficient and half of the state or tap word
   localparam logic [2:0] MUL_IDLE    = 3'd0;
   localparam logic [2:0] MUL_FB1_LO  = 3'd1;
   localparam logic [2:0] MUL_FB1_HI  = 3'd2;
   localparam logic [2:0] MUL_FB2_LO  = 3'd3;
   localparam logic [2:0] MUL_FB2_HI  = 3'd4;
   localparam logic [2:0] MUL_GAIN_LO = 3'd5;
   localparam logic [2:0] MUL_GAIN_HI = 3'd6;

   // Accumulator operations
   localparam logic [2:0] ACC_HOLD      = 3'd0;
   localparam logic [2:0] ACC_LOAD_FB   = 3'd1;
   localparam logic [2:0] ACC_LOAD_GAIN = 3'd2;
   localparam logic [2:0] ACC_ADD       = 3'd3;
   localparam logic [2:0] ACC_ADD_SHIFT = 3'd4;

   // Commands from the controller to the datapath, valid for the current cycle
   typedef struct packed {
      logic       load_x;
      logic [2:0] mul_op;
      logic [2:0] acc_op;
      logic       load_w;
      logic       load_taps;
      logic       shift_hist;
      logic       load_out;
   } cmd_type;

endpackage

/* rtl/core/bwbq_ctrl.sv */
// Sequencer for the biquad: steps the shared multiplier, priming and the result handshake.
`timescale 1ns / 1ps

module bwbq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output bwbq_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FB1L = 4'd1;
   localparam logic [3:0] S_FB1H = 4'd2;
   localparam logic [3:0] S_FB2L = 4'd3;
   localparam logic [3:0] S_FB2H = 4'd4;
   localparam logic [3:0] S_WNEW = 4'd5;
   localparam logic [3:0] S_TAPS = 4'd6;
   localparam logic [3:0] S_GL   = 4'd7;
   localparam logic [3:0] S_GH   = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       primed_ff;
   logic       primed_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and per-cycle commands
   always_comb begin
      state_in       = state_ff;
      primed_in      = primed_ff;
      cmd            = '0;
      cmd.mul_op     = bwbq_pkg::MUL_IDLE;
      cmd.acc_op     = bwbq_pkg::ACC_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_x = 1'b1;
               state_in   = S_FB1L;
            end
         end
         S_FB1L: begin
            cmd.mul_op = bwbq_pkg::MUL_FB1_LO;
            state_in   = S_FB1H;
         end
         S_FB1H: begin
            cmd.mul_op = bwbq_pkg::MUL_FB1_HI;
            cmd.acc_op = bwbq_pkg::ACC_LOAD_FB;
            state_in   = S_FB2L;
         end
         S_FB2L: begin
            cmd.mul_op = bwbq_pkg::MUL_FB2_LO;
            cmd.acc_op = bwbq_pkg::ACC_ADD_SHIFT;
            state_in   = S_FB2H;
         end
         S_FB2H: begin
            cmd.mul_op = bwbq_pkg::MUL_FB2_HI;
            cmd.acc_op = bwbq_pkg::ACC_ADD;
            state_in   = S_WNEW;
         end
         S_WNEW: begin
            cmd.load_w = 1'b1;
            state_in   = S_TAPS;
         end
         S_TAPS: begin
            cmd.load_taps = 1'b1;
            state_in      = S_GL;
         end
         S_GL: begin
            cmd.mul_op = bwbq_pkg::MUL_GAIN_LO;
            state_in   = S_GH;
         end
         S_GH: begin
            cmd.mul_op = bwbq_pkg::MUL_GAIN_HI;
            cmd.acc_op = bwbq_pkg::ACC_LOAD_GAIN;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // first pass after reset only primes the history; drop its result
            if (!primed_ff) begin
               cmd.shift_hist = 1'b1;
               primed_in      = 1'b1;
               state_in       = S_FB1L;
            end else if (out_free) begin
               cmd.shift_hist = 1'b1;
               cmd.load_out   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result valid until the transaction completes
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/core/bwbq_dpath.sv */
// Biquad datapath: settings, history, one shared split multiplier, accumulator, saturation.
`timescale 1ns / 1ps

module bwbq_dpath #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 25,
   parameter int STATE_BITS  = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bwbq_pkg::cmd_type      cmd,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [COEF_BITS-1:0]   csr_data,
   output logic [SAMPLE_BITS-1:0] filtered
);

   localparam int COEF_FRAC = COEF_BITS - 3;
   localparam int TAP_BITS  = STATE_BITS + 3;
   localparam int LO_BITS   = TAP_BITS / 2;
   localparam int HI_BITS   = TAP_BITS - LO_BITS;
   localparam int OPD_BITS  = HI_BITS + 1;
   localparam int PROD_BITS = COEF_BITS + OPD_BITS;
   localparam int ACC_BITS  = COEF_BITS + TAP_BITS + 2;

   localparam logic signed [ACC_BITS-1:0] HALF =
      ACC_BITS'(1) << (COEF_FRAC - 1);
   localparam logic signed [ACC_BITS-1:0] STATE_MAX =
      {{(ACC_BITS - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] STATE_MIN = ~STATE_MAX;
   localparam logic signed [ACC_BITS-1:0] SAMPLE_MAX =
      {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

   logic                          mode_ff;
   logic signed [COEF_BITS-1:0]   gain_ff;
   logic signed [COEF_BITS-1:0]   fb1_ff;
   logic signed [COEF_BITS-1:0]   fb2_ff;
   logic signed [STATE_BITS-1:0]  hist_one_ff;
   logic signed [STATE_BITS-1:0]  hist_two_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [STATE_BITS-1:0]  w_ff;
   logic signed [STATE_BITS-1:0]  w_in;
   logic signed [TAP_BITS-1:0]    taps_ff;
   logic signed [TAP_BITS-1:0]    taps_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic signed [ACC_BITS-1:0]    acc_in;
   logic [SAMPLE_BITS-1:0]        out_ff;
   logic [SAMPLE_BITS-1:0]        out_in;

   logic signed [COEF_BITS-1:0]   coef_sel;
   logic signed [TAP_BITS-1:0]    word_sel;
   logic                          use_hi;
   logic signed [OPD_BITS-1:0]    opd_sel;
   logic signed [TAP_BITS-1:0]    h1_ext;
   logic signed [TAP_BITS-1:0]    h2_ext;
   logic signed [TAP_BITS-1:0]    w_ext;
   logic signed [ACC_BITS-1:0]    prod_ext;
   logic signed [ACC_BITS-1:0]    prod_shl;
   logic signed [ACC_BITS-1:0]    x_shl;
   logic signed [ACC_BITS-1:0]    final_sum;
   logic signed [ACC_BITS-1:0]    rounded;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         gain_ff <= '0;
         fb1_ff  <= '0;
         fb2_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            bwbq_pkg::CSR_FILTER_MODE: mode_ff <= csr_data[0];
            bwbq_pkg::CSR_COEF_GAIN:   gain_ff <= csr_data;
            bwbq_pkg::CSR_COEF_FB1:    fb1_ff  <= csr_data;
            bwbq_pkg::CSR_COEF_FB2:    fb2_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Select coefficient and word half for the shared multiplier
   always_comb begin
      coef_sel = '0;
      word_sel = '0;
      use_hi   = 1'b0;
      unique case (cmd.mul_op)
         bwbq_pkg::MUL_FB1_LO: begin
            coef_sel = fb1_ff;
            word_sel = h1_ext;
         end
         bwbq_pkg::MUL_FB1_HI: begin
            coef_sel = fb1_ff;
            word_sel = h1_ext;
            use_hi   = 1'b1;
         end
         bwbq_pkg::MUL_FB2_LO: begin
            coef_sel = fb2_ff;
            word_sel = h2_ext;
         end
         bwbq_pkg::MUL_FB2_HI: begin
            coef_sel = fb2_ff;
            word_sel = h2_ext;
            use_hi   = 1'b1;
         end
         bwbq_pkg::MUL_GAIN_LO: begin
            coef_sel = gain_ff;
            word_sel = taps_ff;
         end
         bwbq_pkg::MUL_GAIN_HI: begin
            coef_sel = gain_ff;
            word_sel = taps_ff;
            use_hi   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Low half is unsigned, high half carries the sign
   always_comb begin
      if (use_hi) begin
         opd_sel = {word_sel[TAP_BITS-1], word_sel[TAP_BITS-1:LO_BITS]};
      end else begin
         opd_sel = {{(OPD_BITS - LO_BITS){1'b0}}, word_sel[LO_BITS-1:0]};
      end
   end

   assign prod_in = coef_sel * opd_sel;

   assign h1_ext   = TAP_BITS'(hist_one_ff);
   assign h2_ext   = TAP_BITS'(hist_two_ff);
   assign w_ext    = TAP_BITS'(w_ff);
   assign prod_ext = ACC_BITS'(prod_ff);
   assign prod_shl = prod_ext <<< LO_BITS;
   assign x_shl    = ACC_BITS'(x_ff) <<< COEF_FRAC;

   // Accumulate partial products; rounding offset enters on each load, the sample on the feedback load
   always_comb begin
      unique case (cmd.acc_op)
         bwbq_pkg::ACC_LOAD_FB:   acc_in = prod_ext + x_shl + HALF;
         bwbq_pkg::ACC_LOAD_GAIN: acc_in = prod_ext + HALF;
         bwbq_pkg::ACC_ADD:       acc_in = acc_ff + prod_ext;
         bwbq_pkg::ACC_ADD_SHIFT: acc_in = acc_ff + prod_shl;
         default:                 acc_in = acc_ff;
      endcase
   end

   // Close the sum with the last high-half product and drop the fraction
   assign final_sum = acc_ff + prod_shl;
   assign rounded   = final_sum >>> COEF_FRAC;

   // Saturate the new inner term to the state range
   always_comb begin
      if (rounded > STATE_MAX) begin
         w_in = STATE_MAX[STATE_BITS-1:0];
      end else if (rounded < STATE_MIN) begin
         w_in = STATE_MIN[STATE_BITS-1:0];
      end else begin
         w_in = rounded[STATE_BITS-1:0];
      end
   end

   // Saturate the output to the sample range
   always_comb begin
      if (rounded > SAMPLE_MAX) begin
         out_in = SAMPLE_MAX[SAMPLE_BITS-1:0];
      end else if (rounded < SAMPLE_MIN) begin
         out_in = SAMPLE_MIN[SAMPLE_BITS-1:0];
      end else begin
         out_in = rounded[SAMPLE_BITS-1:0];
      end
   end

   // Tap sum: plus twice w1 for low-pass, minus for high-pass
   always_comb begin
      if (mode_ff) begin
         taps_in = w_ext - (h1_ext <<< 1) + h2_ext;
      end else begin
         taps_in = w_ext + (h1_ext <<< 1) + h2_ext;
      end
   end

   // History words
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_one_ff <= '0;
         hist_two_ff <= '0;
      end else if (cmd.shift_hist) begin
         hist_two_ff <= hist_one_ff;
         hist_one_ff <= w_ff;
      end
   end

   // Payload registers; hold the last product while the multiplier is idle
   always_ff @(posedge clock) begin
      if (cmd.mul_op != bwbq_pkg::MUL_IDLE) begin
         prod_ff <= prod_in;
      end
      acc_ff  <= acc_in;
      if (cmd.load_x) begin
         x_ff <= sample;
      end
      if (cmd.load_w) begin
         w_ff <= w_in;
      end
      if (cmd.load_taps) begin
         taps_ff <= taps_in;
      end
      if (cmd.load_out) begin
         out_ff <= out_in;
      end
   end

   assign filtered = out_ff;

endmodule

/* rtl/core/butterworth_biquad_lowpass_highpass.sv */
// Top level of the second-order Butterworth low-pass / high-pass biquad.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  req_tdata: sample
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: filtered
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A sample is accepted only in the idle state and then runs nine sequencer steps, set by the
// single multiplier that computes four feedback and two gain half-products in turn.
// The first sample after reset runs two passes.
// Reset is synchronous; it clears the settings, the history and the primed flag.
// A finished result waits in the output register; a new sample is accepted meanwhile,
// and its last step holds until the previous result has been taken.
`timescale 1ns / 1ps

module butterworth_biquad_lowpass_highpass #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 25,
   parameter int STATE_BITS  = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata: sample [SAMPLE_BITS-1:0], zero padding above
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata: filtered [SAMPLE_BITS-1:0], zero padding above
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [COEF_BITS-1:0]                 csr_data
);

   localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   bwbq_pkg::cmd_type      cmd;
   logic [SAMPLE_BITS-1:0] filtered;

   assign csr_ready = 1'b1;

   bwbq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   bwbq_dpath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .STATE_BITS  (STATE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample    (req_tdata[SAMPLE_BITS-1:0]),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .filtered  (filtered)
   );

   assign rsp_tdata = TDATA_BITS'(filtered);

   // A sample transaction starts a pass, so the input closes on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still open after a sample was accepted");

   // A loaded result is presented on the next cycle
   a_result_presented: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

   // A new result never overwrites one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

endmodule

/* sim/biquad_checker.sv */
// Checker for the biquad: tracks settings, predicts each filtered sample and compares results.
`timescale 1ns / 1ps

module biquad_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // req_tdata: sample [23:0]
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata: filtered [23:0]
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_data,
   output int          mismatches,
   output int          outstanding
);

   localparam int SAMPLE_BITS = 24;
   localparam int COEF_BITS   = 25;
   localparam int STATE_BITS  = 48;
   localparam int FRAC_BITS   = COEF_BITS - 3;

   typedef logic signed [127:0] wide_acc_type;

   // Shadow of the settings and of the filter history
   logic                          highpass = 1'b0;
   logic signed [COEF_BITS-1:0]   gain = '0;
   logic signed [COEF_BITS-1:0]   fb1 = '0;
   logic signed [COEF_BITS-1:0]   fb2 = '0;
   logic signed [STATE_BITS-1:0]  hist_one = '0;
   logic signed [STATE_BITS-1:0]  hist_two = '0;
   logic                          primed = 1'b0;

   logic [SAMPLE_BITS-1:0] filtered_due[$];
   int                     errors = 0;

   // Round half up, then drop the coefficient fraction bits
   function automatic wide_acc_type round_frac(wide_acc_type v);
      return (v + (wide_acc_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   function automatic wide_acc_type clamp(wide_acc_type v, int bits);
      wide_acc_type top;
      top = (wide_acc_type'(1) <<< (bits - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
   endfunction

   // One pass through the filter; advances the history
   function automatic logic [SAMPLE_BITS-1:0] filter_pass(logic signed [SAMPLE_BITS-1:0] x);
      wide_acc_type                 fb_sum;
      wide_acc_type                 inner;
      wide_acc_type                 taps;
      wide_acc_type                 y;
      logic signed [STATE_BITS-1:0] w;
      fb_sum = wide_acc_type'(fb1) * wide_acc_type'(hist_one)
             + wide_acc_type'(fb2) * wide_acc_type'(hist_two);
      inner = clamp(round_frac(fb_sum) + wide_acc_type'(x), STATE_BITS);
      w = inner[STATE_BITS-1:0];
      if (highpass)
         taps = wide_acc_type'(w) - (wide_acc_type'(hist_one) <<< 1);
      else
         taps = wide_acc_type'(w) + (wide_acc_type'(hist_one) <<< 1);
      taps = taps + wide_acc_type'(hist_two);
      y = clamp(round_frac(wide_acc_type'(gain) * taps), SAMPLE_BITS);
      hist_two = hist_one;
      hist_one = w;
      return y[SAMPLE_BITS-1:0];
   endfunction

   task automatic report(string what, logic [SAMPLE_BITS-1:0] due,
                         logic [SAMPLE_BITS-1:0] got);
      if (errors < 10)
         $display("%0t: %s: expected %0d got %0d", $realtime, what,
                  $signed(due), $signed(got));
      errors++;
   endtask

   always @(posedge clock) begin : watch
      logic [SAMPLE_BITS-1:0] due;
      if (reset) begin
         highpass = 1'b0;
         gain     = '0;
         fb1      = '0;
         fb2      = '0;
         hist_one = '0;
         hist_two = '0;
         primed   = 1'b0;
         filtered_due.delete();
      end else begin
         // Compare each result transaction with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_due.size() == 0) begin
               report("unexpected result", '0, rsp_tdata[SAMPLE_BITS-1:0]);
            end else begin
               due = filtered_due.pop_front();
               if (rsp_tdata[SAMPLE_BITS-1:0] !== due)
                  report("filtered mismatch", due, rsp_tdata[SAMPLE_BITS-1:0]);
            end
         end
         // Predict; the first sample after reset primes the history first
         if (req_tvalid && req_tready) begin
            if (!primed) begin
               void'(filter_pass(req_tdata[SAMPLE_BITS-1:0]));
               primed = 1'b1;
            end
            filtered_due.push_back(filter_pass(req_tdata[SAMPLE_BITS-1:0]));
         end
         // Track register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bwbq_pkg::CSR_FILTER_MODE: highpass = csr_data[0];
               bwbq_pkg::CSR_COEF_GAIN:   gain     = csr_data;
               bwbq_pkg::CSR_COEF_FB1:    fb1      = csr_data;
               bwbq_pkg::CSR_COEF_FB2:    fb2      = csr_data;
               default: begin
               end
            endcase
         end
      end
      mismatches  <= errors;
      outstanding <= filtered_due.size();
   end

endmodule

/* sim/tb.sv */
// Testbench top for the biquad: clock, reset, stimulus, settings and the final verdict.
`timescale 1ns / 1ps

module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata: sample [23:0]
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata: filtered [23:0]
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = bwbq_pkg::CSR_FILTER_MODE;
   logic [24:0] csr_data = '0;

   int mismatches;
   int outstanding;
   bit calm = 1'b0;
   int stall_left = 0;

   localparam int SAMPLE_MAX = 8388607;
   localparam int SAMPLE_MIN = -8388608;
   localparam int COEF_MAX   = 16777215;
   localparam int COEF_MIN   = -16777216;

   butterworth_biquad_lowpass_highpass dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   biquad_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result side in short random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [24:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Drain the filter, then write all four registers
   task automatic apply_settings(logic [24:0] mode_word, int gain, int fb1, int fb2);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      write_reg(bwbq_pkg::CSR_FILTER_MODE, mode_word);
      write_reg(bwbq_pkg::CSR_COEF_GAIN, 25'(gain));
      write_reg(bwbq_pkg::CSR_COEF_FB1, 25'(fb1));
      write_reg(bwbq_pkg::CSR_COEF_FB2, 25'(fb2));
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(int x);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x[23:0];
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic int extreme_coef();
      case ($urandom_range(0, 3))
         0:       return COEF_MAX;
         1:       return COEF_MIN;
         2:       return 0;
         default: return int'($urandom());
      endcase
   endfunction

   int seq_lowpass[8]  = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 0, -1, 1};
   int seq_highpass[5] = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 0};
   int seq_rail_hi[4]  = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
   int seq_rail_lo[4]  = '{SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX};

   initial begin
      int g;
      int f1;
      int f2;
      int span;
      int x;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Low-pass near fs/10; the first sample also primes the history
      apply_settings(25'd0, 283116, 4794000, -1731400);
      foreach (seq_lowpass[i]) send_sample(seq_lowpass[i]);
      // High-pass with the same feedback
      apply_settings(25'd1, 2679700, 4794000, -1731400);
      foreach (seq_highpass[i]) send_sample(seq_highpass[i]);
      // Runaway feedback: state and output pin at the top rail; mode bit clear, upper bits set
      apply_settings(25'h1FFFFFE, COEF_MAX, COEF_MAX, COEF_MAX);
      foreach (seq_rail_hi[i]) send_sample(seq_rail_hi[i]);
      // Most negative coefficients in high-pass
      apply_settings(25'h1FFFFFF, COEF_MIN, COEF_MIN, COEF_MIN);
      foreach (seq_rail_lo[i]) send_sample(seq_rail_lo[i]);
      // All-zero coefficients give silence
      apply_settings(25'd0, 0, 0, 0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);

      // Random phases, each with its own settings
      for (int ph = 0; ph < 10; ph++) begin
         case ($urandom_range(0, 3))
            0: begin
               g  = int'($urandom());
               f1 = int'($urandom());
               f2 = int'($urandom());
            end
            1: begin
               g  = extreme_coef();
               f1 = extreme_coef();
               f2 = extreme_coef();
            end
            default: begin
               // Stable pole pair: b2 in (-1, 0], |b1| < 1 - b2
               f2   = -int'($urandom_range(0, 4194000));
               span = 4194304 - f2 - 1;
               f1   = int'($urandom_range(0, span));
               if ($urandom_range(0, 1) == 1) f1 = -f1;
               g    = int'($urandom_range(0, 4194304));
               if ($urandom_range(0, 3) == 0) g = -g;
            end
         endcase
         if (ph == 9) calm = 1'b1;
         apply_settings(25'($urandom()), g, f1, f2);
         for (int n = 0; n < 175; n++) begin
            // Hold off once per phase, but for the calm last one, until every result is back
            if (n == 87 && !calm) begin
               req_tvalid <= 1'b0;
               do @(posedge clock); while (outstanding != 0);
            end
            case ($urandom_range(0, 9))
               0:       x = SAMPLE_MAX;
               1:       x = SAMPLE_MIN;
               2:       x = 0;
               3, 4:    x = int'($urandom_range(0, 8192)) - 4096;
               default: x = int'($urandom());
            endcase
            send_sample(x);
         end
      end

      // Drain and give the verdict
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Stop a hung run
   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/bwbq_pkg.sv
rtl/core/bwbq_ctrl.sv
rtl/core/bwbq_dpath.sv
rtl/core/butterworth_biquad_lowpass_highpass.sv
sim/biquad_checker.sv
sim/tb.sv
